>>> sv/assert_macros.svh
// Assertion helpers. Both expect clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSW_ASSERT_IMP(lbl, ante, cons, msg)
`define RSW_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/rsw_pkg.sv
package rsw_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int DIV_W     = 64;
  localparam int DIVISOR_W = 32;
  localparam int DCNT_W    = 7;
  localparam int MUL_W     = 32;

  localparam logic [DCNT_W-1:0] DIV_SHORT = 7'd33;
  localparam logic [DCNT_W-1:0] DIV_LONG  = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_ABS,
    ST_DIV_MEAN,
    ST_MUL,
    ST_DIV_VP,
    ST_DIV_VS,
    ST_SQ_P,
    ST_SQ_S,
    ST_DONE
  } state_t;

endpackage

>>> sv/rsw_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// Dividend arrives left aligned; nbits sets the iteration count.
module rsw_div import rsw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  input  logic [DCNT_W-1:0]    nbits,
  output logic                 done,
  output logic [DIV_W-1:0]     quot
);

  logic [DIV_W-1:0]     num_r;
  logic [DIV_W-1:0]     quot_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dv_r;
  logic [DCNT_W-1:0]    cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVISOR_W:0]   trial;
  logic                 ge;
  logic [DIVISOR_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, num_r[DIV_W-1]};
    ge       = trial >= {1'b0, dv_r};
    rem_step = ge ? DIVISOR_W'(trial - {1'b0, dv_r}) : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= dividend;
        dv_r   <= divisor;
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        num_r  <= {num_r[DIV_W-2:0], 1'b0};
        rem_r  <= rem_step;
        quot_r <= {quot_r[DIV_W-2:0], ge};
        cnt_r  <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> sv/rsw_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module rsw_mul import rsw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic               done,
  output logic [2*MUL_W-1:0] prod
);

  localparam int CW = $clog2(MUL_W + 1);

  logic [2*MUL_W-1:0] a_r;
  logic [2*MUL_W-1:0] acc_r;
  logic [MUL_W-1:0]   b_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        a_r    <= (2*MUL_W)'(a);
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= CW'(MUL_W);
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r   <= {a_r[2*MUL_W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[MUL_W-1:1]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> sv/rsw_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module rsw_sqrt import rsw_pkg::*; #(
  parameter int RADW = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RADW-1:0]   radicand,
  output logic              done,
  output logic [RADW/2-1:0] root
);

  localparam int RHW = RADW / 2;
  localparam int CW  = $clog2(RHW + 1);

  logic [RADW-1:0] rad_r;
  logic [RHW+1:0]  rem_r;
  logic [RHW-1:0]  root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [RHW+3:0]  remx;
  logic [RHW+3:0]  trial;
  logic            ge;

  always_comb begin
    remx  = {rem_r, rad_r[RADW-1 -: 2]};
    trial = (RHW+4)'({root_r, 2'b01});
    ge    = remx >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(RHW);
      end else if (busy_r) begin
        rad_r  <= {rad_r[RADW-3:0], 2'b00};
        rem_r  <= ge ? (RHW+2)'(remx - trial) : (RHW+2)'(remx);
        root_r <= {root_r[RHW-2:0], ge};
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> sv/running_stats_welford_core.sv
// Running statistics over a stream of signed fixed-point samples.
// Input channel: in_valid/in_ready carry one sample per request.
// Result channel: out_valid/out_ready carry one result per sample: count,
// saturating sum, Welford mean, mean of |x|, min, max, both variances and
// both standard deviations, plus a sticky saturation flag.
// One sample is worked at a time. Its steps run on the shared bit-serial
// units: two 33-bit divides (mean of |x| and mean), a 32-bit multiply, two
// 64-bit divides (the variances) and two roots of RHW bits each, RHW = 32 +
// ceil(FRAC_BITS/2), then the output load; the sample variance divide is
// skipped while count is 1.
// A new sample waits for the last one: in_ready is high only while idle.
// The finished result sits in an output register, so the next sample is
// accepted while the receiver stalls; that sample then waits in the final
// state until the output register frees up.
// Reset (rst_n low, synchronous) clears all statistics and drops out_valid.
module running_stats_welford_core import rsw_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_count,
  output logic signed [63:0]             out_total,
  output logic signed [31:0]             out_mean,
  output logic [31:0]                    out_abs_mean,
  output logic signed [31:0]             out_minimum,
  output logic signed [31:0]             out_maximum,
  output logic [63:0]                    out_var_population,
  output logic [63:0]                    out_var_sample,
  output logic [39:0]                    out_sd_population,
  output logic [39:0]                    out_sd_sample,
  output logic                           out_saturated
);

  `include "assert_macros.svh"

  // radicand is var << FRAC_BITS, padded to an even width
  localparam int RADW = 64 + FRAC_BITS + (FRAC_BITS % 2);
  localparam int RHW  = RADW / 2;

  state_t state_r, state_nxt;

  // running state
  logic [31:0]        cnt_r;
  logic signed [63:0] sum_r;
  logic signed [31:0] mean_r;
  logic [31:0]        mabs_r;
  logic [63:0]        m2_r;
  logic signed [31:0] min_r;
  logic signed [31:0] max_r;
  logic               have_ext_r;
  logic               sat_r;

  // per-sample work registers
  logic signed [31:0] x_r;
  logic [31:0]        dmag_r;
  logic               div_neg_r;
  logic [63:0]        vp_r;
  logic [63:0]        vs_r;
  logic [39:0]        sdp_r;
  logic [39:0]        sds_r;

  // result register
  logic               out_valid_r;
  logic [31:0]        out_count_r;
  logic signed [63:0] out_total_r;
  logic signed [31:0] out_mean_r;
  logic [31:0]        out_mabs_r;
  logic signed [31:0] out_min_r;
  logic signed [31:0] out_max_r;
  logic [63:0]        out_vp_r;
  logic [63:0]        out_vs_r;
  logic [39:0]        out_sdp_r;
  logic [39:0]        out_sds_r;
  logic               out_sat_r;

  // shared unit hookup
  logic               div_start, div_done;
  logic [63:0]        div_dividend, div_q;
  logic [31:0]        div_divisor;
  logic [DCNT_W-1:0]  div_bits;
  logic               mul_start, mul_done;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic               sq_start, sq_done;
  logic [63:0]        sq_src;
  logic [RHW-1:0]     sq_root;

  logic               in_acc;
  logic               out_load;
  logic               div_neg_nxt;

  // step groups, for the checks at the end
  logic               div_step;
  logic               sq_step;

  // accept-cycle datapath
  logic signed [31:0] x_in;
  logic signed [32:0] xe;
  logic [32:0]        ax_in;
  logic               cnt_full;
  logic [31:0]        cnt_inc;
  logic signed [63:0] sum_add;
  logic               sum_ovf;
  logic [33:0]        adiff;
  logic [32:0]        adiff_mag;

  // later steps
  logic signed [33:0] qs;
  logic signed [33:0] delta;
  logic [32:0]        delta_mag;
  logic signed [31:0] mean_new;
  logic signed [33:0] delta2;
  logic [32:0]        delta2_mag;
  logic [63:0]        prod_sh;
  logic [64:0]        m2_add;
  logic [63:0]        m2_new;

  always_comb begin
    x_in      = 32'(in_sample);
    xe        = 33'(x_in);
    ax_in     = xe[32] ? 33'(-xe) : 33'(xe);
    cnt_full  = cnt_r == 32'hFFFF_FFFF;
    cnt_inc   = cnt_full ? cnt_r : cnt_r + 32'd1;
    sum_add   = sum_r + 64'(x_in);
    sum_ovf   = (sum_r[63] == x_in[31]) && (sum_add[63] != sum_r[63]);
    adiff     = 34'(ax_in) - 34'(mabs_r);
    adiff_mag = adiff[33] ? 33'(-adiff) : adiff[32:0];

    qs         = div_neg_r ? -$signed({1'b0, div_q[32:0]})
                           : $signed({1'b0, div_q[32:0]});
    delta      = 34'(x_r) - 34'(mean_r);
    delta_mag  = delta[33] ? 33'(-delta) : delta[32:0];
    mean_new   = 32'(34'(mean_r) + qs);
    delta2     = 34'(x_r) - 34'(mean_new);
    delta2_mag = delta2[33] ? 33'(-delta2) : delta2[32:0];

    prod_sh = mul_p >> FRAC_BITS;
    m2_add  = {1'b0, m2_r} + {1'b0, prod_sh};
    m2_new  = m2_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_add[63:0];
  end

  assign in_ready = state_r == ST_IDLE;
  assign in_acc   = in_valid && in_ready;

  assign div_step = state_r == ST_DIV_ABS || state_r == ST_DIV_MEAN ||
                    state_r == ST_DIV_VP || state_r == ST_DIV_VS;
  assign sq_step  = state_r == ST_SQ_P || state_r == ST_SQ_S;

  // sequencer: next state and unit starts
  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = {adiff_mag, 31'b0};
    div_divisor  = cnt_r;
    div_bits     = DIV_SHORT;
    div_neg_nxt  = div_neg_r;
    mul_start    = 1'b0;
    mul_a        = dmag_r;
    mul_b        = delta2_mag[31:0];
    sq_start     = 1'b0;
    sq_src       = vp_r;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          div_start   = 1'b1;
          div_divisor = cnt_inc;
          div_neg_nxt = adiff[33];
          state_nxt   = ST_DIV_ABS;
        end
      end
      ST_DIV_ABS: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = {delta_mag, 31'b0};
          div_neg_nxt  = delta[33];
          state_nxt    = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start    = 1'b1;
          div_dividend = m2_new;
          div_bits     = DIV_LONG;
          state_nxt    = ST_DIV_VP;
        end
      end
      ST_DIV_VP: begin
        if (div_done) begin
          if (cnt_r > 32'd1) begin
            div_start    = 1'b1;
            div_dividend = m2_r;
            div_divisor  = cnt_r - 32'd1;
            div_bits     = DIV_LONG;
            state_nxt    = ST_DIV_VS;
          end else begin
            sq_start  = 1'b1;
            sq_src    = div_q;
            state_nxt = ST_SQ_P;
          end
        end
      end
      ST_DIV_VS: begin
        if (div_done) begin
          sq_start  = 1'b1;
          state_nxt = ST_SQ_P;
        end
      end
      ST_SQ_P: begin
        if (sq_done) begin
          sq_start  = 1'b1;
          sq_src    = vs_r;
          state_nxt = ST_SQ_S;
        end
      end
      ST_SQ_S: begin
        if (sq_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      mean_r     <= '0;
      mabs_r     <= '0;
      m2_r       <= '0;
      min_r      <= '0;
      max_r      <= '0;
      have_ext_r <= 1'b0;
      sat_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r      <= cnt_inc;
        sum_r      <= sum_ovf ? (x_in[31] ? 64'sh8000_0000_0000_0000
                                          : 64'sh7FFF_FFFF_FFFF_FFFF) : sum_add;
        if (cnt_full || sum_ovf) begin
          sat_r <= 1'b1;
        end
        have_ext_r <= 1'b1;
        if (!have_ext_r || x_in < min_r) begin
          min_r <= x_in;
        end
        if (!have_ext_r || x_in > max_r) begin
          max_r <= x_in;
        end
      end
      if (state_r == ST_DIV_ABS && div_done) begin
        mabs_r <= 32'(34'(mabs_r) + qs);
      end
      if (state_r == ST_DIV_MEAN && div_done) begin
        mean_r <= mean_new;
      end
      if (state_r == ST_MUL && mul_done) begin
        m2_r <= m2_new;
        if (m2_add[64]) begin
          sat_r <= 1'b1;
        end
      end
    end
  end

  // per-sample work registers
  always_ff @(posedge clk) begin
    div_neg_r <= div_neg_nxt;
    if (in_acc) begin
      x_r <= x_in;
    end
    if (state_r == ST_DIV_ABS && div_done) begin
      dmag_r <= delta_mag[31:0];
    end
    if (state_r == ST_DIV_VP && div_done) begin
      vp_r <= div_q;
      vs_r <= '0;
    end
    if (state_r == ST_DIV_VS && div_done) begin
      vs_r <= div_q;
    end
    if (state_r == ST_SQ_P && sq_done) begin
      sdp_r <= 40'(sq_root);
    end
    if (state_r == ST_SQ_S && sq_done) begin
      sds_r <= 40'(sq_root);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= cnt_r;
      out_total_r <= sum_r;
      out_mean_r  <= mean_r;
      out_mabs_r  <= mabs_r;
      out_min_r   <= min_r;
      out_max_r   <= max_r;
      out_vp_r    <= vp_r;
      out_vs_r    <= vs_r;
      out_sdp_r   <= sdp_r;
      out_sds_r   <= sds_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_count          = out_count_r;
  assign out_total          = out_total_r;
  assign out_mean           = out_mean_r;
  assign out_abs_mean       = out_mabs_r;
  assign out_minimum        = out_min_r;
  assign out_maximum        = out_max_r;
  assign out_var_population = out_vp_r;
  assign out_var_sample     = out_vs_r;
  assign out_sd_population  = out_sdp_r;
  assign out_sd_sample      = out_sds_r;
  assign out_saturated      = out_sat_r;

  rsw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_bits),
    .done     (div_done),
    .quot     (div_q)
  );

  rsw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  rsw_sqrt #(
    .RADW (RADW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (RADW'(sq_src) << FRAC_BITS),
    .done     (sq_done),
    .root     (sq_root)
  );

  `RSW_ASSERT_IMP(a_div_done_st, div_done, div_step, "divider finished outside a divide step")
  `RSW_ASSERT_IMP(a_mul_done_st, mul_done, state_r == ST_MUL, "multiply done outside its step")
  `RSW_ASSERT_IMP(a_sq_done_st, sq_done, sq_step, "root unit finished outside a root step")
  `RSW_ASSERT_NXT(a_acc_starts, in_acc, state_r == ST_DIV_ABS && cnt_r != 32'd0, "no work start")
  `RSW_ASSERT_IMP(a_out_count, out_valid_r, out_count_r != 32'd0, "result shown with zero count")

endmodule

>>> tb/sv/running_stats_welford_core_test.sv
module running_stats_welford_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One statistics record, as it leaves the block for each sample.
  typedef struct {
    logic [31:0] count;
    logic [63:0] total;
    logic [31:0] mean;
    logic [31:0] abs_mean;
    logic [31:0] minimum;
    logic [31:0] maximum;
    logic [63:0] var_pop;
    logic [63:0] var_smp;
    logic [39:0] sd_pop;
    logic [39:0] sd_smp;
    logic        sat;
  } stats_t;

  // Directed request: a sample, and whether its result is typed in directly.
  typedef struct {
    logic [31:0] sample;
    bit          typed;
  } sample_row_t;

  localparam longint SUM_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN  = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
  localparam int     N_RANDOM = 1100;
  localparam int     SETTLE   = 400;   // about one sample's latency plus margin

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic signed [31:0] in_sample;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_count;
  logic signed [63:0] out_total;
  logic signed [31:0] out_mean;
  logic [31:0] out_abs_mean;
  logic signed [31:0] out_minimum;
  logic signed [31:0] out_maximum;
  logic [63:0] out_var_population;
  logic [63:0] out_var_sample;
  logic [39:0] out_sd_population;
  logic [39:0] out_sd_sample;
  logic        out_saturated;

  running_stats_welford_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_count(out_count), .out_total(out_total), .out_mean(out_mean),
    .out_abs_mean(out_abs_mean), .out_minimum(out_minimum), .out_maximum(out_maximum),
    .out_var_population(out_var_population), .out_var_sample(out_var_sample),
    .out_sd_population(out_sd_population), .out_sd_sample(out_sd_sample),
    .out_saturated(out_saturated)
  );

  // Predictor state, mirrors the block's statistics registers.
  bit [31:0] seen_cnt;
  longint    acc_sum;
  longint    acc_mean;
  longint    acc_abs_mean;
  bit [63:0] acc_m2;
  longint    lo_seen;
  longint    hi_seen;
  bit        extremes_set;
  bit        sat_seen;

  stats_t expected_stats[$];
  int     mismatch_cnt;
  int     in_idle_pct;
  int     out_stall_pct;
  bit     long_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(sqrt(v * 2^16)), bit by bit over a 128-bit square
  function automatic logic [39:0] root_q16(input logic [63:0] v);
    logic [127:0] target;
    logic [127:0] trial;
    logic [47:0]  r;
    target = {64'd0, v} << 16;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      trial = {80'd0, r | (48'd1 << b)};
      if (trial * trial <= target) r = r | (48'd1 << b);
    end
    return r[39:0];
  endfunction

  // Fold one sample into the running statistics and return the record.
  function automatic stats_t fold_sample(input logic signed [31:0] s);
    stats_t    st;
    longint    x, n, ax, delta, delta2;
    bit [63:0] mag1, mag2, prod, vp, vs;
    x = s;
    if (seen_cnt == 32'hFFFF_FFFF) sat_seen = 1'b1;
    else seen_cnt++;
    n = seen_cnt;

    if (x > 0 && acc_sum > SUM_MAX - x) begin
      acc_sum = SUM_MAX;
      sat_seen = 1'b1;
    end else if (x < 0 && acc_sum < SUM_MIN - x) begin
      acc_sum = SUM_MIN;
      sat_seen = 1'b1;
    end else begin
      acc_sum += x;
    end

    // first sample sets both extremes
    if (!extremes_set) begin
      lo_seen = x;
      hi_seen = x;
      extremes_set = 1'b1;
    end else begin
      if (x < lo_seen) lo_seen = x;
      if (x > hi_seen) hi_seen = x;
    end

    ax = (x < 0) ? -x : x;
    acc_abs_mean += (ax - acc_abs_mean) / n;   // truncates toward zero

    delta = x - acc_mean;
    acc_mean += delta / n;
    delta2 = x - acc_mean;
    mag1 = (delta < 0) ? -delta : delta;
    mag2 = (delta2 < 0) ? -delta2 : delta2;
    prod = (mag1 * mag2) >> 16;
    if (acc_m2 > ~64'd0 - prod) begin
      acc_m2 = ~64'd0;
      sat_seen = 1'b1;
    end else begin
      acc_m2 += prod;
    end

    vp = acc_m2 / 64'(n);
    vs = (n > 1) ? acc_m2 / 64'(n - 1) : 64'd0;

    st.count    = seen_cnt;
    st.total    = acc_sum;
    st.mean     = acc_mean[31:0];
    st.abs_mean = acc_abs_mean[31:0];
    st.minimum  = lo_seen[31:0];
    st.maximum  = hi_seen[31:0];
    st.var_pop  = vp;
    st.var_smp  = vs;
    st.sd_pop   = root_q16(vp);
    st.sd_smp   = root_q16(vs);
    st.sat      = sat_seen;
    return st;
  endfunction

  function automatic bit idle_now(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Offer one sample, hold it until taken, then queue what it should produce.
  task automatic send_sample(input logic [31:0] s, input bit typed);
    stats_t st;
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    st = fold_sample(s);
    if (typed) begin
      // lone sample right after reset: every statistic reads straight off it
      st.count    = 32'd1;
      st.total    = {{32{s[31]}}, s};
      st.mean     = s;
      st.abs_mean = s[31] ? -s : s;
      st.minimum  = s;
      st.maximum  = s;
      st.var_pop  = '0;
      st.var_smp  = '0;
      st.sd_pop   = '0;
      st.sd_smp   = '0;
      st.sat      = 1'b0;
    end
    expected_stats.push_back(st);
    while (idle_now(in_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0:       return $urandom_range(65535) - 32768;          // near zero
      1:       return 32'h8000_0000 + $urandom_range(255);    // bottom edge
      2:       return 32'h7FFF_FFFF - $urandom_range(255);    // top edge
      3:       return {{12{1'b0}}, 20'($urandom)} + 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic field_check(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t %s: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Result monitor: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    stats_t st;
    if (rst_n && out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%0t result with no request pending", $realtime);
      end else begin
        st = expected_stats.pop_front();
        field_check("count", {32'd0, st.count}, {32'd0, out_count});
        field_check("total", st.total, out_total);
        field_check("mean", {32'd0, st.mean}, {32'd0, out_mean});
        field_check("abs_mean", {32'd0, st.abs_mean}, {32'd0, out_abs_mean});
        field_check("minimum", {32'd0, st.minimum}, {32'd0, out_minimum});
        field_check("maximum", {32'd0, st.maximum}, {32'd0, out_maximum});
        field_check("var_population", st.var_pop, out_var_population);
        field_check("var_sample", st.var_smp, out_var_sample);
        field_check("sd_population", {24'd0, st.sd_pop}, {24'd0, out_sd_population});
        field_check("sd_sample", {24'd0, st.sd_smp}, {24'd0, out_sd_sample});
        field_check("saturated", {63'd0, st.sat}, {63'd0, out_saturated});
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_now(out_stall_pct);
      end
    end
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sample_row_t rows [18];
    int          wait_cnt;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    mismatch_cnt = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    long_hold_req = 1'b0;
    seen_cnt = '0;
    acc_sum = 0;
    acc_mean = 0;
    acc_abs_mean = 0;
    acc_m2 = '0;
    lo_seen = 0;
    hi_seen = 0;
    extremes_set = 1'b0;
    sat_seen = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first sample typed in, then extremes and sign flips.
    rows = '{
      '{32'h7FFF_FFFF, 1'b1}, '{32'h8000_0000, 1'b0}, '{32'h0000_0000, 1'b0},
      '{32'hFFFF_FFFF, 1'b0}, '{32'h0000_0001, 1'b0}, '{32'h8000_0000, 1'b0},
      '{32'h8000_0000, 1'b0}, '{32'h7FFF_FFFF, 1'b0}, '{32'h7FFF_FFFF, 1'b0},
      '{32'h0001_0000, 1'b0}, '{32'hFFFF_0000, 1'b0}, '{32'h8000_0000, 1'b0},
      '{32'h7FFF_FFFF, 1'b0}, '{32'h8000_0001, 1'b0}, '{32'h5555_5555, 1'b0},
      '{32'hAAAA_AAAA, 1'b0}, '{32'h0000_8000, 1'b0}, '{32'hFFFF_8000, 1'b0}
    };
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed);

    // Random phases: no idling, sender idle, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 48; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 48; end
        default: begin in_idle_pct = 37; out_stall_pct = 37; end
      endcase
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        // receiver holds off while requests keep coming: input must back up
        if (ph == 2 && k == 10) long_hold_req = 1'b1;
        // sender pause until the block has drained
        if (ph == 1 && k == 50) begin
          in_valid <= 1'b0;
          while (expected_stats.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        send_sample(rand_sample(), 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (expected_stats.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < SETTLE) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (mismatch_cnt == 0 && expected_stats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
